>>> sv/rlk_pkg.sv
package rlk_pkg;

    // Timer counter width and the width of the tick-count registers.
    localparam int TIMER_WIDTH = 16;
    localparam int TICKS_WIDTH = 16;
    localparam int CMP_WIDTH = (TIMER_WIDTH > TICKS_WIDTH) ? TIMER_WIDTH : TICKS_WIDTH;

    localparam int CHANNEL_WIDTH = 7;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 16;

    // Channel hopping constants.
    localparam logic [CHANNEL_WIDTH-1:0] HOP_STEP = 7'd15;
    localparam logic [CHANNEL_WIDTH-1:0] HOP_LIMIT = 7'd120;
    localparam logic [CHANNEL_WIDTH-1:0] CHANNEL_MAX = 7'd127;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BEACON_WAIT = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STANDBY = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STATUS_REQUEST = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANSWER_WAIT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SELF_WORK = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_CHANNEL = 3'd5;

    // Packet kinds received from the radio.
    localparam logic [1:0] KIND_BEACON = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Packet kinds to send.
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_BEACON_ANSWER = 2'd1;
    localparam logic [1:0] SEND_STATUS_REQUEST = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT              = 3'd0,
        ST_HOP               = 3'd1,
        ST_LISTEN            = 3'd2,
        ST_WAIT_ANSWER_SEND  = 3'd3,
        ST_STANDBY           = 3'd4,
        ST_WAIT_REQUEST_SEND = 3'd5,
        ST_WAIT_STATUS       = 3'd6
    } state_t;

    typedef struct packed {
        logic       tick;
        logic       rx_ready;
        logic       rx_checksum_ok;
        logic [1:0] rx_kind;
        logic       rx_line_power;
        logic       tx_busy;
    } poll_t;

    typedef struct packed {
        logic [CHANNEL_WIDTH-1:0] channel;
        logic [1:0]               send_kind;
        logic                     rx_consumed;
        logic                     line_power;
        logic                     self_work;
        logic [2:0]               state_code;
    } result_t;

    typedef struct packed {
        logic [TICKS_WIDTH-1:0]   beacon_wait_ticks;
        logic [TICKS_WIDTH-1:0]   standby_ticks;
        logic [TICKS_WIDTH-1:0]   status_request_ticks;
        logic [TICKS_WIDTH-1:0]   answer_wait_ticks;
        logic [TICKS_WIDTH-1:0]   self_work_ticks;
        logic [CHANNEL_WIDTH-1:0] start_channel;
    } cfg_t;

    // Handshake between the input stage and the result stage.
    typedef struct packed {
        logic valid;
        poll_t item;
    } stage_t;

    // A timer has run out once its count reaches the programmed period.
    function automatic logic timer_elapsed(logic [TIMER_WIDTH-1:0] count,
                                           logic [TICKS_WIDTH-1:0] period);
        return CMP_WIDTH'(count) >= CMP_WIDTH'(period);
    endfunction

    // Count up by one on a tick, holding at all ones.
    function automatic logic [TIMER_WIDTH-1:0] timer_advance(logic [TIMER_WIDTH-1:0] count,
                                                             logic tick);
        logic [TIMER_WIDTH-1:0] result;
        result = count;
        if (tick && (count != {TIMER_WIDTH{1'b1}}))
        begin
            result = count + TIMER_WIDTH'(1);
        end
        return result;
    endfunction

endpackage

>>> sv/rlk_cfg_regs.sv
module rlk_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_en,
    input  logic [rlk_pkg::CFG_INDEX_WIDTH-1:0] index,
    input  logic [rlk_pkg::CFG_DATA_WIDTH-1:0]  data,
    output rlk_pkg::cfg_t                       cfg
);

    rlk_pkg::cfg_t cfg_reg;

    // Register file; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beacon_wait_ticks    <= rlk_pkg::TICKS_WIDTH'(50);
            cfg_reg.standby_ticks        <= rlk_pkg::TICKS_WIDTH'(5000);
            cfg_reg.status_request_ticks <= rlk_pkg::TICKS_WIDTH'(1000);
            cfg_reg.answer_wait_ticks    <= rlk_pkg::TICKS_WIDTH'(100);
            cfg_reg.self_work_ticks      <= rlk_pkg::TICKS_WIDTH'(30000);
            cfg_reg.start_channel        <= rlk_pkg::CHANNEL_WIDTH'(2);
        end
        else if (write_en)
        begin
            unique case (index)
                rlk_pkg::REG_BEACON_WAIT:
                    cfg_reg.beacon_wait_ticks <= data[rlk_pkg::TICKS_WIDTH-1:0];
                rlk_pkg::REG_STANDBY:
                    cfg_reg.standby_ticks <= data[rlk_pkg::TICKS_WIDTH-1:0];
                rlk_pkg::REG_STATUS_REQUEST:
                    cfg_reg.status_request_ticks <= data[rlk_pkg::TICKS_WIDTH-1:0];
                rlk_pkg::REG_ANSWER_WAIT:
                    cfg_reg.answer_wait_ticks <= data[rlk_pkg::TICKS_WIDTH-1:0];
                rlk_pkg::REG_SELF_WORK:
                    cfg_reg.self_work_ticks <= data[rlk_pkg::TICKS_WIDTH-1:0];
                rlk_pkg::REG_START_CHANNEL:
                    cfg_reg.start_channel <= data[rlk_pkg::CHANNEL_WIDTH-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/rlk_in_stage.sv
module rlk_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    input  rlk_pkg::poll_t  item,
    input  logic            take,
    output logic            stall,
    output rlk_pkg::stage_t held
);

    logic           valid_reg;
    logic           valid_next;
    rlk_pkg::poll_t item_reg;
    logic           load;

    // The register takes a new beat whenever it is empty or being drained.
    assign stall = valid_reg && !take;
    assign load = valid && !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign held.valid = valid_reg;
    assign held.item = item_reg;

endmodule

>>> sv/rlk_core.sv
module rlk_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  rlk_pkg::poll_t   item,
    input  rlk_pkg::cfg_t    cfg,
    output rlk_pkg::result_t result
);

    rlk_pkg::state_t                      state_reg, state_next;
    logic [rlk_pkg::CHANNEL_WIDTH-1:0]    channel_reg, channel_next;
    logic                                 power_reg, power_next;
    logic                                 self_work_reg, self_work_next;
    logic [rlk_pkg::TIMER_WIDTH-1:0]      beacon_cnt_reg, beacon_cnt_next;
    logic [rlk_pkg::TIMER_WIDTH-1:0]      standby_cnt_reg, standby_cnt_next;
    logic [rlk_pkg::TIMER_WIDTH-1:0]      request_cnt_reg, request_cnt_next;
    logic [rlk_pkg::TIMER_WIDTH-1:0]      answer_cnt_reg, answer_cnt_next;
    logic [rlk_pkg::TIMER_WIDTH-1:0]      session_cnt_reg, session_cnt_next;
    logic [rlk_pkg::CHANNEL_WIDTH:0]      hop_sum;
    logic [1:0]                           send;
    logic                                 consumed;
    logic                                 beacon_ok;
    logic                                 status_ok;

    assign beacon_ok = item.rx_checksum_ok && (item.rx_kind == rlk_pkg::KIND_BEACON);
    assign status_ok = item.rx_checksum_ok && (item.rx_kind == rlk_pkg::KIND_STATUS);
    assign hop_sum = {1'b0, channel_reg} + {1'b0, rlk_pkg::HOP_STEP};

    // Next state: timers advance on a tick first, then the state logic sees them.
    always_comb
    begin
        state_next = state_reg;
        channel_next = channel_reg;
        power_next = power_reg;
        self_work_next = self_work_reg;
        beacon_cnt_next = rlk_pkg::timer_advance(beacon_cnt_reg, item.tick);
        standby_cnt_next = rlk_pkg::timer_advance(standby_cnt_reg, item.tick);
        request_cnt_next = rlk_pkg::timer_advance(request_cnt_reg, item.tick);
        answer_cnt_next = rlk_pkg::timer_advance(answer_cnt_reg, item.tick);
        session_cnt_next = rlk_pkg::timer_advance(session_cnt_reg, item.tick);
        send = rlk_pkg::SEND_NONE;
        consumed = 1'b0;

        unique case (state_reg)
            rlk_pkg::ST_HOP:
            begin
                if (rlk_pkg::timer_elapsed(session_cnt_next, cfg.self_work_ticks))
                begin
                    self_work_next = 1'b1;
                end
                if (channel_reg < rlk_pkg::HOP_LIMIT)
                begin
                    if (hop_sum > {1'b0, rlk_pkg::CHANNEL_MAX})
                    begin
                        channel_next = rlk_pkg::CHANNEL_MAX;
                    end
                    else
                    begin
                        channel_next = hop_sum[rlk_pkg::CHANNEL_WIDTH-1:0];
                    end
                end
                else
                begin
                    channel_next = '0;
                end
                beacon_cnt_next = '0;
                state_next = rlk_pkg::ST_LISTEN;
            end
            rlk_pkg::ST_LISTEN:
            begin
                if (rlk_pkg::timer_elapsed(beacon_cnt_next, cfg.beacon_wait_ticks))
                begin
                    state_next = rlk_pkg::ST_HOP;
                end
                else if (item.rx_ready)
                begin
                    consumed = 1'b1;
                    if (beacon_ok)
                    begin
                        send = rlk_pkg::SEND_BEACON_ANSWER;
                        self_work_next = 1'b0;
                        state_next = rlk_pkg::ST_WAIT_ANSWER_SEND;
                    end
                end
            end
            rlk_pkg::ST_WAIT_ANSWER_SEND:
            begin
                if (!item.tx_busy)
                begin
                    request_cnt_next = '0;
                    standby_cnt_next = '0;
                    state_next = rlk_pkg::ST_STANDBY;
                end
            end
            rlk_pkg::ST_STANDBY:
            begin
                if (item.rx_ready)
                begin
                    consumed = 1'b1;
                    if (status_ok)
                    begin
                        power_next = item.rx_line_power;
                        standby_cnt_next = '0;
                    end
                end
                else if (rlk_pkg::timer_elapsed(request_cnt_next, cfg.status_request_ticks))
                begin
                    request_cnt_next = '0;
                    send = rlk_pkg::SEND_STATUS_REQUEST;
                    state_next = rlk_pkg::ST_WAIT_REQUEST_SEND;
                end
                else if (rlk_pkg::timer_elapsed(standby_cnt_next, cfg.standby_ticks))
                begin
                    session_cnt_next = '0;
                    state_next = rlk_pkg::ST_HOP;
                end
            end
            rlk_pkg::ST_WAIT_REQUEST_SEND:
            begin
                if (!item.tx_busy)
                begin
                    answer_cnt_next = '0;
                    state_next = rlk_pkg::ST_WAIT_STATUS;
                end
            end
            rlk_pkg::ST_WAIT_STATUS:
            begin
                if (rlk_pkg::timer_elapsed(answer_cnt_next, cfg.answer_wait_ticks))
                begin
                    state_next = rlk_pkg::ST_STANDBY;
                end
                else if (item.rx_ready)
                begin
                    consumed = 1'b1;
                    if (status_ok)
                    begin
                        standby_cnt_next = '0;
                        power_next = item.rx_line_power;
                        state_next = rlk_pkg::ST_STANDBY;
                    end
                end
            end
            default:
            begin
                // Init, and any code outside the state list, loads the start channel.
                session_cnt_next = '0;
                channel_next = cfg.start_channel;
                state_next = rlk_pkg::ST_HOP;
            end
        endcase
    end

    // State registers move only when a poll beat is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlk_pkg::ST_INIT;
            channel_reg <= '0;
            power_reg <= 1'b0;
            self_work_reg <= 1'b0;
            beacon_cnt_reg <= '0;
            standby_cnt_reg <= '0;
            request_cnt_reg <= '0;
            answer_cnt_reg <= '0;
            session_cnt_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            channel_reg <= channel_next;
            power_reg <= power_next;
            self_work_reg <= self_work_next;
            beacon_cnt_reg <= beacon_cnt_next;
            standby_cnt_reg <= standby_cnt_next;
            request_cnt_reg <= request_cnt_next;
            answer_cnt_reg <= answer_cnt_next;
            session_cnt_reg <= session_cnt_next;
        end
    end

    // The result reports the state after the update.
    assign result.channel = channel_next;
    assign result.send_kind = send;
    assign result.rx_consumed = consumed;
    assign result.line_power = power_next;
    assign result.self_work = self_work_next;
    assign result.state_code = state_next;

endmodule

>>> sv/rlk_out_stage.sv
module rlk_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rlk_pkg::result_t item,
    input  logic             stall,
    output logic             free,
    output logic             valid,
    output rlk_pkg::result_t result
);

    logic             valid_reg;
    logic             valid_next;
    rlk_pkg::result_t result_reg;

    // The register may be refilled when empty or when its beat leaves this cycle.
    assign free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= item;
        end
    end

    assign valid = valid_reg;
    assign result = result_reg;

endmodule

>>> sv/radio_link_keepalive_fsm.sv
// Channel   Direction  Handshake                  Payload
// poll      in         poll_valid / poll_stall    poll (rlk_pkg::poll_t)
// result    out        result_valid / result_stall result (rlk_pkg::result_t)
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One poll beat is accepted per cycle while poll_stall is low.
// The path is the poll register, one pass of state and timer logic, and the result register.
// Reset clears the state machine, the timers and both stage valids; registers load defaults.
// A stalled result holds while the poll register takes one more beat, then poll_stall rises.
// Configuration writes are always ready and take effect on the next cycle.
module radio_link_keepalive_fsm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                poll_valid,
    output logic                                poll_stall,
    input  rlk_pkg::poll_t                      poll,
    output logic                                result_valid,
    input  logic                                result_stall,
    output rlk_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlk_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rlk_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    rlk_pkg::cfg_t    cfg;
    rlk_pkg::stage_t  held;
    rlk_pkg::result_t core_result;
    logic             out_free;
    logic             step;

    assign cfg_ready = 1'b1;

    // A held poll beat is processed when the result register can take it.
    assign step = held.valid && out_free;

    rlk_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_valid && cfg_ready),
        .index    (cfg_index),
        .data     (cfg_data),
        .cfg      (cfg)
    );

    rlk_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (poll_valid),
        .item  (poll),
        .take  (step),
        .stall (poll_stall),
        .held  (held)
    );

    rlk_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (held.item),
        .cfg    (cfg),
        .result (core_result)
    );

    rlk_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step),
        .item   (core_result),
        .stall  (result_stall),
        .free   (out_free),
        .valid  (result_valid),
        .result (result)
    );

endmodule

>>> sv/rlk_checker.sv
module rlk_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             poll_valid,
    input logic             poll_stall,
    input logic             result_valid,
    input logic             result_stall,
    input rlk_pkg::result_t result
);

    // A stalled result beat keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // A packet send only starts on entry to a wait-for-send state.
    a_send_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.send_kind == rlk_pkg::SEND_BEACON_ANSWER) |->
        result.state_code == rlk_pkg::ST_WAIT_ANSWER_SEND)
        else $error("beacon answer without wait-answer-send state");

    a_request_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.send_kind == rlk_pkg::SEND_STATUS_REQUEST) |->
        result.state_code == rlk_pkg::ST_WAIT_REQUEST_SEND)
        else $error("status request without wait-request-send state");

    // Entering the hop state never reads a packet or sends one.
    a_hop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.state_code == rlk_pkg::ST_HOP) |->
        !result.rx_consumed && (result.send_kind == rlk_pkg::SEND_NONE))
        else $error("packet activity on entry to hop state");

    // With the result side free, an offered poll beat is never stalled.
    a_no_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
        poll_valid && !result_stall |-> !poll_stall)
        else $error("poll side stalled with result side free");

endmodule

bind radio_link_keepalive_fsm rlk_checker u_rlk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
